// ===== design/lzsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzsd_pkg
// Shared constants and controller/datapath interface types for the LZSS
// stream decoder.
// ----------------------------------------------------------------------------
package lzsd_pkg;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int MAX_COPY_DEF   = 18;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [4:0] MIN_COPY   = 5'd3;
  localparam logic [3:0] FLAG_UNITS = 4'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic restart;     // make the ring read as spaces, rewind write pointer
    logic literal;     // emit code_byte and write it into the ring
    logic hold_low;    // keep code_byte as the low byte of a pair position
    logic start_copy;  // code_byte completes a pair: issue the first ring read
    logic copy_step;   // emit one copied byte
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a byte this cycle
    logic copy_last;   // the byte of the next copy step ends the copy
  } dp_status_t;

endpackage

// ===== design/lzss_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// lzss_stream_decoder
// LZSS decompressor with a ring-buffer history and 12-bit position pairs.
// ----------------------------------------------------------------------------
// Usage: compressed bytes enter on code_byte with in_valid/in_ready; each
// transfer may carry chunk_start, which restarts the decoder (ring reads as
// spaces again, write pointer back to RING_DEPTH - MAX_COPY, partial token
// dropped) and handles that byte as a flag byte. Decoded bytes leave on
// out_byte with out_valid/out_ready; run_last marks the final byte caused by
// one input byte.
// Tokens: a flag byte or the first byte of a pair gives no output. A
// literal is written straight into the output register. A pair's second
// byte starts a copy of L bytes, L = 3..MAX_COPY; the single ring read port
// yields one copied byte per cycle unless the output register is stalled,
// and each copied byte passes the registered ring read, then the output register.
// Reset: all control state clears. The ring is never swept: a fill count
// of bytes written since reset or the last restart tells which entries still
// read as spaces, so the block takes input straight after reset.
// Stall: the output register holds its byte while out_ready is low; the
// copy pauses and in_ready stays low until that byte is taken.
// ----------------------------------------------------------------------------
module lzss_stream_decoder
  import lzsd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_COPY   = MAX_COPY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] code_byte,
  input  logic       chunk_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  lzsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .code_byte  (code_byte),
    .chunk_start(chunk_start),
    .status     (status),
    .cmd        (cmd)
  );

  lzsd_datapath #(
    .RING_DEPTH(RING_DEPTH),
    .MAX_COPY  (MAX_COPY)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .code_byte(code_byte),
    .cmd      (cmd),
    .status   (status),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .run_last (run_last)
  );

  // No input is taken while a copy is streaming.
  a_no_input_during_copy: assert property (@(posedge clk) disable iff (rst)
    cmd.copy_step |-> !in_ready)
    else $error("input accepted during a copy");

  // A literal is only handled when the output register can take it.
  a_literal_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.literal |-> status.out_free)
    else $error("literal issued with output register occupied");

  // The last copy step returns the controller to idle.
  a_copy_ends: assert property (@(posedge clk) disable iff (rst)
    (cmd.copy_step && status.copy_last) |=> !cmd.copy_step)
    else $error("copy continued past its last byte");

endmodule

// ===== design/lzsd_ram.sv =====
// ----------------------------------------------------------------------------
// lzsd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/lzsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzsd_ctrl
// Token controller: tracks the flag group and token phase, gates the input
// channel and sequences copies through the datapath.
// ----------------------------------------------------------------------------
module lzsd_ctrl
  import lzsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] code_byte,
  input  logic       chunk_start,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_COPY = 1'b1;

  localparam logic [1:0] PH_FLAG   = 2'd0;
  localparam logic [1:0] PH_UNIT   = 2'd1;
  localparam logic [1:0] PH_SECOND = 2'd2;

  logic [0:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [7:0] flag_bits, flag_bits_next;
  logic [3:0] flags_remaining, flags_remaining_next;

  logic       accept;
  logic [1:0] phase_eff;
  logic [3:0] remaining_dec;

  assign remaining_dec = (flags_remaining != 4'd0) ? flags_remaining - 4'd1 : flags_remaining;

  always_comb begin
    state_next           = state;
    phase_next           = phase;
    flag_bits_next       = flag_bits;
    flags_remaining_next = flags_remaining;
    cmd                  = '0;
    in_ready             = (state == ST_IDLE) && status.out_free;
    accept               = in_valid && in_ready;
    phase_eff            = chunk_start ? PH_FLAG : phase;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.restart = chunk_start;
          case (phase_eff)
            PH_UNIT: begin
              if (flag_bits[0]) begin
                cmd.literal          = 1'b1;
                flag_bits_next       = flag_bits >> 1;
                flags_remaining_next = remaining_dec;
                phase_next           = (remaining_dec != 4'd0) ? PH_UNIT : PH_FLAG;
              end else begin
                cmd.hold_low = 1'b1;
                phase_next   = PH_SECOND;
              end
            end
            PH_SECOND: begin
              // The unit is closed now; no input is taken until the copy ends.
              cmd.start_copy       = 1'b1;
              state_next           = ST_COPY;
              flag_bits_next       = flag_bits >> 1;
              flags_remaining_next = remaining_dec;
              phase_next           = (remaining_dec != 4'd0) ? PH_UNIT : PH_FLAG;
            end
            default: begin
              flag_bits_next       = code_byte;
              flags_remaining_next = FLAG_UNITS;
              phase_next           = PH_UNIT;
            end
          endcase
        end
      end
      ST_COPY: begin
        cmd.copy_step = status.out_free;
        if (status.out_free && status.copy_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      phase           <= PH_FLAG;
      flag_bits       <= '0;
      flags_remaining <= '0;
    end else begin
      state           <= state_next;
      phase           <= phase_next;
      flag_bits       <= flag_bits_next;
      flags_remaining <= flags_remaining_next;
    end
  end

endmodule

// ===== design/lzsd_datapath.sv =====
// ----------------------------------------------------------------------------
// lzsd_datapath
// History ring, write pointer, fill count, copy address and length counters,
// read forwarding and the output register.
// ----------------------------------------------------------------------------
module lzsd_datapath
  import lzsd_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int MAX_COPY   = MAX_COPY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] code_byte,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam int LW = $clog2(MAX_COPY + 1);
  localparam logic [AW-1:0] WP_START   = AW'(RING_DEPTH - MAX_COPY);
  localparam logic [AW:0]   FILL_FULL  = (AW+1)'(RING_DEPTH);
  localparam logic [4:0]    COPY_LIMIT = 5'(MAX_COPY);

  logic [AW-1:0] wp;
  logic [AW:0]   fill_count;
  logic [7:0]    held_low;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] remain;
  logic          fwd;
  logic [7:0]    fwd_data;
  logic          hit;

  logic          we, re;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic [7:0]    copy_byte;
  logic [11:0]   pos_full;
  logic [AW-1:0] pos;
  logic [4:0]    len_raw;
  logic [LW-1:0] len;
  logic          load;

  // Entries are written in order from WP_START, so an entry holds written
  // data exactly when its distance from WP_START is below the fill count;
  // every other entry still reads as a space.
  function automatic logic in_window(input logic [AW-1:0] addr, input logic [AW:0] fill);
    logic [AW-1:0] offset;
    offset = addr - WP_START;
    return {1'b0, offset} < fill;
  endfunction

  assign pos_full  = {code_byte[7:4], held_low};
  assign pos       = pos_full[AW-1:0];
  assign len_raw   = {1'b0, code_byte[3:0]} + MIN_COPY;
  assign len       = (len_raw > COPY_LIMIT) ? LW'(COPY_LIMIT) : LW'(len_raw);
  assign copy_byte = fwd ? fwd_data : (hit ? rdata : SPACE_CHAR);

  assign status.out_free  = !out_valid || out_ready;
  assign status.copy_last = (remain == LW'(1));

  assign we    = cmd.literal || cmd.copy_step;
  assign wdata = cmd.literal ? code_byte : copy_byte;
  assign load  = we;
  assign re    = cmd.start_copy || (cmd.copy_step && !status.copy_last);
  assign raddr = cmd.start_copy ? pos : rd_addr;

  lzsd_ram #(
    .WIDTH(8),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (we),
    .waddr(wp),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      wp         <= WP_START;
      fill_count <= '0;
    end else if (we) begin
      wp <= wp + AW'(1);
      if (fill_count != FILL_FULL) begin
        fill_count <= fill_count + (AW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= wdata;
      run_last <= cmd.literal || status.copy_last;
    end
    if (cmd.hold_low) begin
      held_low <= code_byte;
    end
    if (cmd.start_copy) begin
      remain  <= len;
      rd_addr <= pos + AW'(1);
      fwd     <= 1'b0;
      hit     <= in_window(pos, fill_count);
    end else if (cmd.copy_step) begin
      remain <= remain - LW'(1);
      if (!status.copy_last) begin
        // A read of the entry written in this same cycle returns old data,
        // so the byte just copied is passed straight to the next step.
        rd_addr  <= rd_addr + AW'(1);
        fwd      <= (rd_addr == wp);
        fwd_data <= copy_byte;
        hit      <= in_window(rd_addr, fill_count);
      end
    end
  end

endmodule
